FILE: rtl/core/fosss_pkg.sv
`default_nettype none

package fosss_pkg;

	// Configuration port
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 11;

	localparam logic [CFG_IDX_W-1:0] CFG_PWM_FAN_MODE      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_START_DUTY        = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_START_VOLTAGE = 2'd2;

	localparam logic [10:0] MIN_START_VOLTAGE_RST = 11'd510;

	// DAC transfer: n = 4728800 - 4314 * (V - 100) microvolts, V in 0.01 V
	localparam logic [10:0] DAC_V_MIN    = 11'd510;
	localparam logic [10:0] DAC_V_MAX    = 11'd1198;
	localparam logic [10:0] DAC_V_OFFSET = 11'd100;
	localparam logic [22:0] DAC_NUM_UV   = 23'd4728800;
	localparam logic [22:0] DAC_SLOPE_UV = 23'd4314;
	localparam logic [13:0] DUTY_FULL    = 14'd10000;
	localparam logic [3:0]  DIV_LAST_BIT = 4'd13;

	// Sequencer constants
	localparam logic [10:0] RAMP_STEP  = 11'd10;
	localparam logic [11:0] RAMP_MAX   = 12'd2047;
	localparam logic [7:0]  WAIT_DCDC  = 8'hFF;
	localparam logic [7:0]  WAIT_RAMP  = 8'd5;
	localparam logic [7:0]  SPEED_MAX  = 8'd100;
	localparam logic [1:0]  PWR_ALL_ON = 2'b11;

	typedef enum logic [6:0] {
		SEQ_IDLE     = 7'b0000001,
		SEQ_PREBIAS  = 7'b0000010,
		SEQ_DCDC     = 7'b0000100,
		SEQ_RAMP     = 7'b0001000,
		SEQ_PWMSTART = 7'b0010000,
		SEQ_NORMAL   = 7'b0100000,
		SEQ_SHUT     = 7'b1000000
	} seq_state_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic load;    // capture the input beat
		logic start;   // launch the DAC duty division
		logic commit;  // apply the tick to the sequencer registers
	} ctl_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic div_done;
	} dp_sts_t;

endpackage

`default_nettype wire

FILE: rtl/core/fosss_div.sv
`default_nettype none

module fosss_div
	import fosss_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [10:0] volts,
	input  wire logic [12:0] supply,
	output logic             done,
	output logic [13:0]      duty
);

	typedef enum logic [2:0] {
		D_IDLE = 3'b001,
		D_PREP = 3'b010,
		D_STEP = 3'b100
	} div_state_t;

	div_state_t         st_q;
	logic               done_q;
	logic signed [24:0] n_q;
	logic [12:0]        mv_q;
	logic [24:0]        rem_q;
	logic [25:0]        dvs_q;
	logic [13:0]        q_q;
	logic [3:0]         cnt_q;

	logic [10:0]        v_cl;
	logic [10:0]        v_off;
	logic [22:0]        prod;
	logic signed [24:0] n_d;
	logic [24:0]        n10;
	logic [26:0]        lim;
	logic               n_pos;
	logic               fits;

	always_comb begin
		if (volts > DAC_V_MAX) begin
			v_cl = DAC_V_MAX;
		end else if (volts < DAC_V_MIN) begin
			v_cl = DAC_V_MIN;
		end else begin
			v_cl = volts;
		end
		v_off = v_cl - DAC_V_OFFSET;
		prod  = 23'(v_off) * DAC_SLOPE_UV;
		n_d   = $signed({2'b00, DAC_NUM_UV}) - $signed({2'b00, prod});
	end

	assign n_pos = !n_q[24] && (n_q != 25'sd0);
	assign n10   = 25'(n_q[23:0]) * 25'd10;
	assign lim   = 27'(mv_q) * 27'd10000;
	assign fits  = {2'b00, n10} < lim;
	assign done  = done_q;
	assign duty  = q_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= D_IDLE;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (st_q)
				D_IDLE: begin
					if (start) begin
						st_q <= D_PREP;
					end
				end
				D_PREP: begin
					if (!n_pos || (mv_q != 13'd0 && fits)) begin
						st_q <= n_pos ? D_STEP : D_IDLE;
						done_q <= !n_pos;
					end else begin
						st_q   <= D_IDLE;
						done_q <= 1'b1;
					end
				end
				D_STEP: begin
					if (cnt_q == 4'd0) begin
						st_q   <= D_IDLE;
						done_q <= 1'b1;
					end
				end
				default: begin
					st_q <= D_IDLE;
				end
			endcase
		end
	end

	// Restoring division, one quotient bit per cycle, MSB first.
	always_ff @(posedge clk) begin
		unique case (st_q)
			D_IDLE: begin
				if (start) begin
					n_q  <= n_d;
					mv_q <= supply;
				end
			end
			D_PREP: begin
				if (!n_pos) begin
					q_q <= 14'd0;
				end else if (mv_q == 13'd0 || !fits) begin
					q_q <= DUTY_FULL;
				end else begin
					rem_q <= n10;
					dvs_q <= {mv_q, 13'd0};
					cnt_q <= DIV_LAST_BIT;
					q_q   <= 14'd0;
				end
			end
			D_STEP: begin
				if ({1'b0, rem_q} >= dvs_q) begin
					rem_q <= rem_q - dvs_q[24:0];
					q_q   <= {q_q[12:0], 1'b1};
				end else begin
					q_q   <= {q_q[12:0], 1'b0};
				end
				dvs_q <= dvs_q >> 1;
				cnt_q <= cnt_q - 4'd1;
			end
			default: begin
			end
		endcase
	end

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("divider done lasted more than one cycle");

	a_duty_range: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> q_q <= DUTY_FULL)
		else $error("DAC duty above full scale");

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> st_q == D_IDLE)
		else $error("divider started while busy");

endmodule

`default_nettype wire

FILE: rtl/core/fosss_dp.sv
`default_nettype none

module fosss_dp
	import fosss_pkg::*;
#(
	parameter int unsigned PWM_STEPS = 1000
)
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
	input  wire logic [10:0]           target_voltage,
	input  wire logic [7:0]            target_speed,
	input  wire logic [12:0]           supply_mv,
	input  wire logic                  turbo_mode,
	input  wire logic                  speed_update_request,
	input  wire logic                  upload_done,
	input  wire ctl_cmd_t              cmd,
	output dp_sts_t                    sts,
	output logic                       fan_power_enable,
	output logic                       dcdc_enable,
	output logic [9:0]                 fan_pwm_duty,
	output logic [13:0]                dac_duty,
	output logic                       upload_request,
	output logic                       output_on
);

	localparam logic [9:0] PWM_FULL = 10'(PWM_STEPS);

	// Configuration registers
	logic        mode_q;
	logic [9:0]  start_duty_q;
	logic [10:0] min_volt_q;

	// Captured input beat
	logic [10:0] tv_q;
	logic [7:0]  ts_q;
	logic [12:0] mv_q;
	logic        turbo_q;
	logic        sur_q;
	logic        ud_q;

	// Sequencer registers
	seq_state_t  seq_q;
	logic [7:0]  wait_q;
	logic [10:0] ramp_q;
	logic [9:0]  duty_q;
	logic [13:0] dac_q;
	logic        upl_q;
	logic        upd_q;
	logic [1:0]  pwr_q;

	seq_state_t  seq_d;
	logic [7:0]  wait_d;
	logic [10:0] ramp_d;
	logic [9:0]  duty_d;
	logic [13:0] dac_d;
	logic        upl_d;
	logic        upd_d;
	logic [1:0]  pwr_d;

	logic        upl_pre;
	logic        upd_pre;
	logic        off;
	logic [11:0] ramp_sum;
	logic [10:0] ramp_inc;
	logic [10:0] ramp_trb;
	logic [10:0] v_sel;
	logic [6:0]  speed_idx;
	logic [9:0]  pwm_val;
	logic [9:0]  pwm_lut [128];
	logic        div_done;
	logic [13:0] div_duty;

	// Speed percent to PWM steps, one constant entry per percent.
	for (genvar i = 0; i < 128; i++) begin : g_lut
		if (i <= 100) begin : g_used
			assign pwm_lut[i] = 10'((i * PWM_STEPS) / 100);
		end else begin : g_spare
			assign pwm_lut[i] = 10'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= 1'b0;
			start_duty_q <= 10'd0;
			min_volt_q   <= MIN_START_VOLTAGE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_PWM_FAN_MODE:      mode_q       <= cfg_wdata[0];
				CFG_START_DUTY:        start_duty_q <= cfg_wdata[9:0];
				CFG_MIN_START_VOLTAGE: min_volt_q   <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			tv_q    <= target_voltage;
			ts_q    <= target_speed;
			mv_q    <= supply_mv;
			turbo_q <= turbo_mode;
			sur_q   <= speed_update_request;
			ud_q    <= upload_done;
		end
	end

	assign off       = (tv_q == 11'd0) || (ts_q == 8'd0);
	assign ramp_sum  = {1'b0, ramp_q} + {1'b0, RAMP_STEP};
	assign ramp_inc  = (ramp_sum > RAMP_MAX) ? RAMP_MAX[10:0] : ramp_sum[10:0];
	assign ramp_trb  = (ramp_inc > tv_q) ? tv_q : ramp_inc;
	assign speed_idx = (ts_q > SPEED_MAX) ? SPEED_MAX[6:0] : ts_q[6:0];
	assign pwm_val   = mode_q ? pwm_lut[speed_idx] : PWM_FULL;
	assign upl_pre   = upl_q & ~ud_q;
	assign upd_pre   = upd_q | sur_q;

	// Voltage whose DAC duty the coming tick may need.
	always_comb begin
		unique case (seq_q)
			SEQ_PREBIAS: v_sel = min_volt_q;
			SEQ_RAMP:    v_sel = (ramp_q >= tv_q) ? tv_q : ramp_inc;
			SEQ_NORMAL:  v_sel = turbo_q ? ramp_trb : tv_q;
			default:     v_sel = tv_q;
		endcase
	end

	fosss_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.start),
		.volts  (v_sel),
		.supply (mv_q),
		.done   (div_done),
		.duty   (div_duty)
	);

	assign sts.div_done = div_done;

	always_comb begin
		seq_d  = seq_q;
		wait_d = wait_q;
		ramp_d = ramp_q;
		duty_d = duty_q;
		dac_d  = dac_q;
		upl_d  = upl_pre;
		upd_d  = upd_pre;
		pwr_d  = pwr_q;
		unique case (seq_q)
			SEQ_PREBIAS: begin
				if (!upl_pre) begin
					ramp_d = min_volt_q;
					dac_d  = div_duty;
					upl_d  = 1'b1;
					wait_d = WAIT_DCDC;
					seq_d  = SEQ_DCDC;
				end
			end
			SEQ_DCDC: begin
				if (!upl_pre) begin
					if (wait_q != 8'd0) begin
						wait_d = wait_q - 8'd1;
					end else begin
						pwr_d = PWR_ALL_ON;
						seq_d = mode_q ? SEQ_PWMSTART : SEQ_RAMP;
					end
				end
			end
			SEQ_RAMP: begin
				if (off) begin
					seq_d = SEQ_SHUT;
				end
				if (!upl_pre) begin
					if (ramp_q >= tv_q) begin
						dac_d = div_duty;
						seq_d = SEQ_NORMAL;
						upl_d = 1'b1;
					end else if (wait_q != 8'd0) begin
						wait_d = wait_q - 8'd1;
					end else begin
						ramp_d = ramp_inc;
						dac_d  = div_duty;
						wait_d = WAIT_RAMP;
						upl_d  = 1'b1;
					end
				end
			end
			SEQ_PWMSTART: begin
				duty_d = pwm_val;
				seq_d  = SEQ_NORMAL;
				upl_d  = 1'b1;
			end
			SEQ_NORMAL: begin
				if (off) begin
					seq_d = SEQ_SHUT;
				end
				if (upd_pre && !upl_pre) begin
					if (!turbo_q) begin
						duty_d = pwm_val;
						dac_d  = mode_q ? 14'd0 : div_duty;
						ramp_d = tv_q;
						upl_d  = 1'b1;
						upd_d  = 1'b0;
					end else if (wait_q != 8'd0) begin
						wait_d = wait_q - 8'd1;
					end else if (!mode_q) begin
						// Slow turbo ramp; the request stays open until the target is hit.
						ramp_d = ramp_trb;
						dac_d  = div_duty;
						wait_d = WAIT_RAMP;
						upl_d  = 1'b1;
						upd_d  = (ramp_trb < tv_q);
					end else begin
						duty_d = pwm_val;
						upl_d  = 1'b1;
						upd_d  = 1'b0;
					end
				end
			end
			SEQ_SHUT: begin
				pwr_d  = 2'b00;
				duty_d = 10'd0;
				dac_d  = 14'd0;
				upl_d  = 1'b1;
				ramp_d = 11'd0;
				upd_d  = 1'b0;
				seq_d  = SEQ_IDLE;
			end
			default: begin
				seq_d = SEQ_IDLE;
				if (tv_q != 11'd0 || ts_q != 8'd0) begin
					dac_d  = 14'd0;
					wait_d = 8'd0;
					duty_d = start_duty_q;
					upl_d  = 1'b1;
					seq_d  = mode_q ? SEQ_DCDC : SEQ_PREBIAS;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q  <= SEQ_IDLE;
			wait_q <= 8'd0;
			ramp_q <= 11'd0;
			duty_q <= 10'd0;
			dac_q  <= 14'd0;
			upl_q  <= 1'b0;
			upd_q  <= 1'b0;
			pwr_q  <= 2'b00;
		end else if (cmd.commit) begin
			seq_q  <= seq_d;
			wait_q <= wait_d;
			ramp_q <= ramp_d;
			duty_q <= duty_d;
			dac_q  <= dac_d;
			upl_q  <= upl_d;
			upd_q  <= upd_d;
			pwr_q  <= pwr_d;
		end
	end

	assign fan_power_enable = pwr_q[0];
	assign dcdc_enable      = pwr_q[1];
	assign fan_pwm_duty     = duty_q;
	assign dac_duty         = dac_q;
	assign upload_request   = upl_q;
	assign output_on        = (seq_q == SEQ_RAMP) || (seq_q == SEQ_PWMSTART) ||
	                          (seq_q == SEQ_NORMAL);

endmodule

`default_nettype wire

FILE: rtl/core/fosss_ctrl.sv
`default_nettype none

module fosss_ctrl
	import fosss_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_valid,
	output logic         in_ready,
	output logic         out_valid,
	input  wire logic    out_ready,
	input  wire dp_sts_t sts,
	output ctl_cmd_t     cmd
);

	typedef enum logic [3:0] {
		P_IDLE  = 4'b0001,
		P_CALC  = 4'b0010,
		P_WAIT  = 4'b0100,
		P_APPLY = 4'b1000
	} phase_t;

	phase_t phase_q;
	logic   out_valid_q;

	assign in_ready   = (phase_q == P_IDLE);
	assign cmd.load   = in_valid && in_ready;
	assign cmd.start  = (phase_q == P_CALC);
	// The tick is applied only once the previous result beat has left.
	assign cmd.commit = (phase_q == P_APPLY) && (!out_valid_q || out_ready);
	assign out_valid  = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= P_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (phase_q)
				P_IDLE: begin
					if (cmd.load) begin
						phase_q <= P_CALC;
					end
				end
				P_CALC: begin
					phase_q <= P_WAIT;
				end
				P_WAIT: begin
					if (sts.div_done) begin
						phase_q <= P_APPLY;
					end
				end
				P_APPLY: begin
					if (cmd.commit) begin
						phase_q <= P_IDLE;
					end
				end
				default: begin
					phase_q <= P_IDLE;
				end
			endcase
		end
	end

	a_commit_beat: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> out_valid_q)
		else $error("applied tick produced no result beat");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> !in_ready)
		else $error("second beat taken while a tick is in flight");

	a_done_waited: assert property (@(posedge clk) disable iff (!arst_n)
		sts.div_done |-> phase_q == P_WAIT)
		else $error("division finished with no tick waiting on it");

endmodule

`default_nettype wire

FILE: rtl/core/fan_output_softstart_sequencer_unit.sv
// An accepted input beat yields its result beat once its tick is applied; the DAC duty
// is set directly when it saturates or is zero, else the 14-bit serial division runs.
// The divider produces one quotient bit per cycle, and a new beat is taken only after
// the previous tick has been applied.
// Reset (arst_n low, asynchronous): sequencer idle, enables off, duties and flags
// cleared, configuration at its defaults; no clearing pass is needed.
`default_nettype none

module fan_output_softstart_sequencer_unit
	import fosss_pkg::*;
#(
	parameter int unsigned PWM_STEPS = 1000
)
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic [10:0]           target_voltage,
	input  wire logic [7:0]            target_speed,
	input  wire logic [12:0]           supply_mv,
	input  wire logic                  turbo_mode,
	input  wire logic                  speed_update_request,
	input  wire logic                  upload_done,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic                       fan_power_enable,
	output logic                       dcdc_enable,
	output logic [9:0]                 fan_pwm_duty,
	output logic [13:0]                dac_duty,
	output logic                       upload_request,
	output logic                       output_on
);

	// Each input beat is one control tick of the fan power sequencer. The
	// controller captures the beat, launches the DAC duty division for the
	// voltage the tick may need, waits for it, and then applies the tick to
	// the sequencer registers in a single cycle.
	//
	// The sequencer registers themselves drive the result ports. They change
	// only when a tick is applied, and a tick is applied only once the
	// previous result beat has been taken, so the result stays stable while
	// out_valid is high and back-pressure on the output never loses a beat.

	ctl_cmd_t cmd;
	dp_sts_t  sts;

	fosss_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// The datapath holds the configuration registers, the captured beat, the
	// seven-state sequencer with its wait counter, ramp setpoint and duty
	// registers, and the serial divider that turns volts into a DAC duty.
	fosss_dp #(
		.PWM_STEPS (PWM_STEPS)
	) u_dp (
		.clk                  (clk),
		.arst_n               (arst_n),
		.cfg_we               (cfg_we),
		.cfg_index            (cfg_index),
		.cfg_wdata            (cfg_wdata),
		.target_voltage       (target_voltage),
		.target_speed         (target_speed),
		.supply_mv            (supply_mv),
		.turbo_mode           (turbo_mode),
		.speed_update_request (speed_update_request),
		.upload_done          (upload_done),
		.cmd                  (cmd),
		.sts                  (sts),
		.fan_power_enable     (fan_power_enable),
		.dcdc_enable          (dcdc_enable),
		.fan_pwm_duty         (fan_pwm_duty),
		.dac_duty             (dac_duty),
		.upload_request       (upload_request),
		.output_on            (output_on)
	);

endmodule

`default_nettype wire
